// File: hw/rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants of the greedy box suppression block.
// ----------------------------------------------------------------------------
`default_nettype none

package gbn_pkg;

  localparam int COORD_W = 16;
  localparam int SCORE_W = 16;
  localparam int GEOM_W  = 4 * COORD_W;
  localparam int INDEX_W = 6;

  localparam logic [15:0] SCORE_THR_RESET = 16'd32768;
  localparam logic [15:0] IOU_THR_RESET   = 16'd6554;

  localparam logic CFG_SCORE_THR = 1'b0;
  localparam logic CFG_IOU_THR   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_DECIDE,
    ST_KLATCH,
    ST_SUP_NEXT,
    ST_SUP_OV,
    ST_SUP_MUL,
    ST_SUP_UNI,
    ST_SUP_CMP,
    ST_FINISH
  } gbn_state_t;

  typedef struct packed {
    logic load;
    logic find_start;
    logic find_run;
    logic take_best;
    logic kept_sel;
    logic latch_kept;
    logic sup_skip;
    logic sup_ov;
    logic sup_mul;
    logic sup_uni;
    logic sup_cmp;
    logic finish;
  } gbn_cmd_t;

  typedef struct packed {
    logic find_done;
    logic best_valid;
    logic best_below;
    logic sup_done;
    logic sup_pending;
  } gbn_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/gbn_ram.sv
// ----------------------------------------------------------------------------
// gbn_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/gbn_ctrl.sv
// ----------------------------------------------------------------------------
// gbn_ctrl
// Sequencer: load, best-box search, keep decision and suppression sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_ctrl import gbn_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        last_box,
  input  wire gbn_status_t status,
  output gbn_cmd_t         cmd,
  output logic             busy
);

  gbn_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && last_box) state_next = ST_FIND;
      end
      ST_FIND: begin
        if (status.find_done) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!status.best_valid || status.best_below) state_next = ST_FINISH;
        else state_next = ST_KLATCH;
      end
      ST_KLATCH:   state_next = ST_SUP_NEXT;
      ST_SUP_NEXT: begin
        if (status.sup_done) state_next = ST_FIND;
        else if (status.sup_pending) state_next = ST_SUP_OV;
      end
      ST_SUP_OV:   state_next = ST_SUP_MUL;
      ST_SUP_MUL:  state_next = ST_SUP_UNI;
      ST_SUP_UNI:  state_next = ST_SUP_CMP;
      ST_SUP_CMP:  state_next = ST_SUP_NEXT;
      ST_FINISH:   state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy           = 1'b0;
        cmd.load       = start;
        cmd.find_start = start && last_box;
      end
      ST_FIND:   cmd.find_run = 1'b1;
      ST_DECIDE: begin
        cmd.kept_sel  = 1'b1;
        cmd.take_best = status.best_valid && !status.best_below;
      end
      ST_KLATCH: cmd.latch_kept = 1'b1;
      ST_SUP_NEXT: begin
        cmd.find_start = status.sup_done;
        cmd.sup_skip   = !status.sup_done && !status.sup_pending;
      end
      ST_SUP_OV:  cmd.sup_ov  = 1'b1;
      ST_SUP_MUL: cmd.sup_mul = 1'b1;
      ST_SUP_UNI: cmd.sup_uni = 1'b1;
      ST_SUP_CMP: cmd.sup_cmp = 1'b1;
      ST_FINISH:  cmd.finish  = 1'b1;
      default:    cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/gbn_dp.sv
// ----------------------------------------------------------------------------
// gbn_dp
// Box stores, pending bits, best-score search and the IoU test datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_dp import gbn_pkg::*; #(
  parameter int MAX_BOXES = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire gbn_cmd_t                  cmd,
  output gbn_status_t                    status,
  input  wire logic signed [COORD_W-1:0] center_x,
  input  wire logic signed [COORD_W-1:0] center_y,
  input  wire logic signed [COORD_W-1:0] box_width,
  input  wire logic signed [COORD_W-1:0] box_height,
  input  wire logic [SCORE_W-1:0]        class_score,
  input  wire logic                      cfg_valid,
  input  wire logic                      cfg_index,
  input  wire logic [15:0]               cfg_data,
  output logic                           strobe,
  output logic [INDEX_W-1:0]             kept_index,
  output logic                           none_kept,
  output logic                           overflowed,
  output logic                           last_result
);

  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_BOXES);

  logic [15:0] score_thr, iou_thr;
  logic [CW-1:0] count, scan_idx, sup_idx;
  logic ovf;
  logic [MAX_BOXES-1:0] pending;
  logic rd_vld;
  logic [AW-1:0] idx_d, best_idx, buf_idx;
  logic best_valid;
  logic [SCORE_W-1:0] best_score;
  logic have_buf;
  logic store_we;
  logic [SCORE_W-1:0] score_rd;
  logic [GEOM_W-1:0] geom_rd;
  logic [AW-1:0] geom_raddr;

  // Kept box geometry and the per-candidate pipeline registers.
  logic signed [COORD_W-1:0] kx, ky, kw, kh;
  logic signed [31:0] area_a, area_b;
  logic signed [18:0] ow, oh;
  logic signed [37:0] inter;
  logic neg;
  logic signed [34:0] sum4;
  logic signed [38:0] uni;
  logic signed [53:0] lhs;

  always_ff @(posedge clk) begin
    if (rst) begin
      score_thr <= SCORE_THR_RESET;
      iou_thr   <= IOU_THR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SCORE_THR: score_thr <= cfg_data;
        CFG_IOU_THR:   iou_thr   <= cfg_data;
        default:       score_thr <= score_thr;
      endcase
    end
  end

  assign store_we   = cmd.load && (count < CAP);
  assign geom_raddr = cmd.kept_sel ? best_idx : sup_idx[AW-1:0];

  gbn_ram #(.WIDTH(GEOM_W), .DEPTH(MAX_BOXES)) u_geom_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[AW-1:0]),
    .wdata ({box_height, box_width, center_y, center_x}),
    .raddr (geom_raddr),
    .rdata (geom_rd)
  );

  gbn_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_BOXES)) u_score_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[AW-1:0]),
    .wdata (class_score),
    .raddr (scan_idx[AW-1:0]),
    .rdata (score_rd)
  );

  // Edge and overlap arithmetic in units of half an LSB: edges are 2*c -/+ s.
  logic signed [COORD_W-1:0] bx, by, bw, bh;
  logic signed [17:0] blx, bhx, bly, bhy, klx, khx, kly, khy;
  logic signed [17:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [55:0] rhs;
  logic suppress;

  assign bx = geom_rd[15:0];
  assign by = geom_rd[31:16];
  assign bw = geom_rd[47:32];
  assign bh = geom_rd[63:48];

  assign blx = {bx[15], bx, 1'b0} - {{2{bw[15]}}, bw};
  assign bhx = {bx[15], bx, 1'b0} + {{2{bw[15]}}, bw};
  assign bly = {by[15], by, 1'b0} - {{2{bh[15]}}, bh};
  assign bhy = {by[15], by, 1'b0} + {{2{bh[15]}}, bh};
  assign klx = {kx[15], kx, 1'b0} - {{2{kw[15]}}, kw};
  assign khx = {kx[15], kx, 1'b0} + {{2{kw[15]}}, kw};
  assign kly = {ky[15], ky, 1'b0} - {{2{kh[15]}}, kh};
  assign khy = {ky[15], ky, 1'b0} + {{2{kh[15]}}, kh};

  assign lo_x = (blx > klx) ? blx : klx;
  assign hi_x = (bhx < khx) ? bhx : khx;
  assign lo_y = (bly > kly) ? bly : kly;
  assign hi_y = (bhy < khy) ? bhy : khy;

  // The union can be zero or negative with negative sizes, so compare signed.
  assign rhs = $signed({1'b0, iou_thr}) * uni;
  assign suppress = neg ? (iou_thr == 16'd0) : ($signed({{2{lhs[53]}}, lhs}) >= rhs);

  always_ff @(posedge clk) begin
    if (cmd.latch_kept) begin
      kx     <= bx;
      ky     <= by;
      kw     <= bw;
      kh     <= bh;
      area_a <= bw * bh;
    end
    if (cmd.sup_ov) begin
      ow     <= {hi_x[17], hi_x} - {lo_x[17], lo_x};
      oh     <= {hi_y[17], hi_y} - {lo_y[17], lo_y};
      area_b <= bw * bh;
    end
    if (cmd.sup_mul) begin
      inter <= ow * oh;
      neg   <= ow[18] || oh[18];
      sum4  <= {({area_a[31], area_a} + {area_b[31], area_b}), 2'b00};
    end
    if (cmd.sup_uni) begin
      uni <= {{4{sum4[34]}}, sum4} - {inter[37], inter};
      lhs <= {inter, 16'h0000};
    end
  end

  // Job control, search and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      ovf        <= 1'b0;
      pending    <= '1;
      have_buf   <= 1'b0;
      rd_vld     <= 1'b0;
      best_valid <= 1'b0;
      scan_idx   <= '0;
      sup_idx    <= '0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cmd.load) begin
        if (count < CAP) count <= count + 1'b1;
        else ovf <= 1'b1;
      end
      if (cmd.find_start) begin
        scan_idx   <= '0;
        rd_vld     <= 1'b0;
        best_valid <= 1'b0;
      end
      if (cmd.find_run) begin
        rd_vld <= (scan_idx < count);
        idx_d  <= scan_idx[AW-1:0];
        if (scan_idx < count) scan_idx <= scan_idx + 1'b1;
        // Ascending scan with a strict compare keeps the lower index on ties.
        if (rd_vld && pending[idx_d] && (!best_valid || score_rd > best_score)) begin
          best_valid <= 1'b1;
          best_score <= score_rd;
          best_idx   <= idx_d;
        end
      end
      if (cmd.take_best) begin
        pending[best_idx] <= 1'b0;
        buf_idx           <= best_idx;
        have_buf          <= 1'b1;
        if (have_buf) begin
          strobe      <= 1'b1;
          kept_index  <= INDEX_W'(buf_idx);
          none_kept   <= 1'b0;
          overflowed  <= ovf;
          last_result <= 1'b0;
        end
      end
      if (cmd.latch_kept) sup_idx <= '0;
      if (cmd.sup_skip) sup_idx <= sup_idx + 1'b1;
      if (cmd.sup_cmp) begin
        if (suppress) pending[sup_idx[AW-1:0]] <= 1'b0;
        sup_idx <= sup_idx + 1'b1;
      end
      if (cmd.finish) begin
        strobe      <= 1'b1;
        kept_index  <= have_buf ? INDEX_W'(buf_idx) : '0;
        none_kept   <= !have_buf;
        overflowed  <= ovf;
        last_result <= 1'b1;
        count       <= '0;
        ovf         <= 1'b0;
        pending     <= '1;
        have_buf    <= 1'b0;
      end
    end
  end

  assign status.find_done   = (scan_idx == count) && !rd_vld;
  assign status.best_valid  = best_valid;
  assign status.best_below  = best_score < score_thr;
  assign status.sup_done    = (sup_idx == count);
  assign status.sup_pending = pending[sup_idx[AW-1:0]];

endmodule

`default_nettype wire

// File: hw/rtl/greedy_box_nms.sv
// ----------------------------------------------------------------------------
// greedy_box_nms
// Greedy non-maximum suppression over one class with an IoU threshold.
// ----------------------------------------------------------------------------
// A box without last_box is stored and causes no result.
// After last_box each pass scans the score RAM to find the best pending box,
// then sweeps the geometry RAM, testing each pending candidate against it.
// Results are one-cycle strobes. Synchronous reset restores the thresholds and empties the job.
`default_nettype none

module greedy_box_nms import gbn_pkg::*; #(
  parameter int MAX_BOXES = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [COORD_W-1:0] center_x,
  input  wire logic signed [COORD_W-1:0] center_y,
  input  wire logic signed [COORD_W-1:0] box_width,
  input  wire logic signed [COORD_W-1:0] box_height,
  input  wire logic [SCORE_W-1:0]        class_score,
  input  wire logic                      last_box,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic                      cfg_index,
  input  wire logic [15:0]               cfg_data,
  output logic                           strobe,
  output logic [INDEX_W-1:0]             kept_index,
  output logic                           none_kept,
  output logic                           overflowed,
  output logic                           last_result
);

  gbn_cmd_t    cmd;
  gbn_status_t status;

  assign cfg_ready = 1'b1;

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .last_box (last_box),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  gbn_dp #(.MAX_BOXES(MAX_BOXES)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .center_x    (center_x),
    .center_y    (center_y),
    .box_width   (box_width),
    .box_height  (box_height),
    .class_score (class_score),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .strobe      (strobe),
    .kept_index  (kept_index),
    .none_kept   (none_kept),
    .overflowed  (overflowed),
    .last_result (last_result)
  );

  // The final beat of a job appears only once the block is idle again.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last_result |-> !busy) else $error("final beat while busy");

  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    strobe && none_kept |-> last_result && kept_index == '0)
    else $error("malformed empty marker");

  a_last_starts_pass: assert property (@(posedge clk) disable iff (rst)
    start && !busy && last_box |=> busy) else $error("pass did not start");

endmodule

`default_nettype wire

// File: tb/sv/greedy_box_nms_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// greedy_box_nms_test
// Self-checking bench for the greedy box suppression block: boxes are loaded
// in jobs of random size, a local model ranks, thresholds and suppresses them,
// and every kept-index beat is compared against the model in order.
// ----------------------------------------------------------------------------
module greedy_box_nms_test;
  import gbn_pkg::*;

  localparam int CAP = 64;

  typedef struct {
    bit                 is_cfg;
    logic               cidx;
    logic [15:0]        cdata;
    logic signed [15:0] x, y, w, h;
    logic [15:0]        s;
    logic               last;
  } beat_t;

  typedef struct {
    logic [5:0] idx;
    logic       none, ovf, last;
  } kept_t;

  logic clk = 1'b0, rst = 1'b1;
  logic start = 1'b0, cfg_valid = 1'b0, cfg_index = CFG_SCORE_THR, last_box = 1'b0;
  logic signed [15:0] center_x = '0, center_y = '0, box_width = '0, box_height = '0;
  logic [15:0] class_score = '0, cfg_data = '0;
  logic busy, cfg_ready, strobe, none_kept, overflowed, last_result;
  logic [5:0] kept_index;

  greedy_box_nms #(.MAX_BOXES(CAP)) i_dut (
    .clk, .rst, .start, .busy, .center_x, .center_y, .box_width, .box_height,
    .class_score, .last_box, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .strobe, .kept_index, .none_kept, .overflowed, .last_result
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  beat_t pending[$];
  kept_t kept_fifo[$];

  // Model state.
  logic signed [15:0] gx[CAP], gy[CAP], gw[CAP], gh[CAP];
  logic [15:0] gscore[CAP];
  int box_cnt = 0;
  bit ovf_seen = 0;
  logic [15:0] score_thr = SCORE_THR_RESET, iou_thr = IOU_THR_RESET;

  int errors = 0, boxes_in = 0, jobs_done = 0, beats_out = 0, issued = 0, quiet = 0;
  bit box_taken = 0, cfg_taken = 0, stim_done = 0;

  function automatic longint overlap(longint c1, longint s1, longint c2, longint s2);
    longint lo, hi;
    lo = (2*c1 - s1 > 2*c2 - s2) ? 2*c1 - s1 : 2*c2 - s2;
    hi = (2*c1 + s1 < 2*c2 + s2) ? 2*c1 + s1 : 2*c2 + s2;
    return hi - lo;
  endfunction

  function automatic bit iou_hits(int k, int m);
    longint ow, oh, inter, uni;
    ow = overlap(gx[m], gw[m], gx[k], gw[k]);
    oh = overlap(gy[m], gh[m], gy[k], gh[k]);
    if (ow < 0 || oh < 0) return iou_thr == 0;
    inter = ow * oh;
    uni = 4 * (longint'(gw[k]) * gh[k] + longint'(gw[m]) * gh[m]) - inter;
    return inter * 65536 >= longint'(iou_thr) * uni;
  endfunction

  task automatic nms_step(beat_t b);
    int order[CAP];
    bit alive[CAP];
    int i, j, key, k, n;
    kept_t r;
    bit any;
    if (box_cnt < CAP) begin
      gx[box_cnt] = b.x; gy[box_cnt] = b.y; gw[box_cnt] = b.w; gh[box_cnt] = b.h;
      gscore[box_cnt] = b.s;
      box_cnt++;
    end else ovf_seen = 1;
    if (!b.last) return;
    n = box_cnt;
    any = 0;
    for (i = 0; i < n; i++) begin
      order[i] = i;
      alive[i] = 1;
    end
    // Stable insertion sort: equal scores keep load order.
    for (i = 1; i < n; i++) begin
      key = order[i];
      j = i;
      while (j > 0 && gscore[order[j-1]] < gscore[key]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = key;
    end
    for (i = 0; i < n; i++) begin
      k = order[i];
      if (alive[k] && gscore[k] >= score_thr) begin
        r.idx = 6'(k); r.none = 0; r.ovf = ovf_seen; r.last = 0;
        kept_fifo = {kept_fifo, r};
        any = 1;
        for (j = i + 1; j < n; j++)
          if (alive[order[j]] && iou_hits(k, order[j])) alive[order[j]] = 0;
      end else alive[k] = 0;
    end
    if (!any) begin
      r.idx = 0; r.none = 1; r.ovf = ovf_seen; r.last = 1;
      kept_fifo = {kept_fifo, r};
    end else kept_fifo[$].last = 1;
    box_cnt = 0;
    ovf_seen = 0;
    jobs_done++;
  endtask

  // Monitor: check results, then fold in whatever was accepted at this edge.
  always @(posedge clk) begin
    kept_t e;
    beat_t b;
    if (!rst) begin
      if (strobe) begin
        beats_out++;
        if (kept_fifo.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat: index %0d", kept_index);
        end else begin
          e = kept_fifo.pop_front();
          if (kept_index !== e.idx || none_kept !== e.none || overflowed !== e.ovf ||
              last_result !== e.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp idx %0d none %b ovf %b last %b, got %0d %b %b %b",
                       e.idx, e.none, e.ovf, e.last,
                       kept_index, none_kept, overflowed, last_result);
          end
        end
      end
      if (start && !busy) begin
        b.x = center_x; b.y = center_y; b.w = box_width; b.h = box_height;
        b.s = class_score; b.last = last_box; b.is_cfg = 0;
        nms_step(b);
        boxes_in++;
        box_taken = 1;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SCORE_THR) score_thr = cfg_data;
        else iou_thr = cfg_data;
        cfg_taken = 1;
      end
      if (busy || strobe || start || kept_fifo.size() != 0) quiet = 0;
      else quiet++;
    end
  end

  // Driver: one beat at a time; register writes wait for a quiet block.
  always @(negedge clk) begin
    bit n_start, n_cfg, no_idle;
    if (!rst) begin
      n_start = start && !box_taken;
      n_cfg = cfg_valid && !cfg_taken;
      box_taken = 0;
      cfg_taken = 0;
      no_idle = issued >= 150 && issued < 260;
      if (!n_start && !n_cfg && pending.size() != 0 &&
          (no_idle || $urandom_range(99) >= 10)) begin
        if (pending[0].is_cfg) begin
          if (quiet >= 16) begin
            cfg_index <= pending[0].cidx;
            cfg_data <= pending[0].cdata;
            n_cfg = 1;
            void'(pending.pop_front());
          end
        end else begin
          center_x <= pending[0].x; center_y <= pending[0].y;
          box_width <= pending[0].w; box_height <= pending[0].h;
          class_score <= pending[0].s; last_box <= pending[0].last;
          n_start = 1;
          issued++;
          void'(pending.pop_front());
        end
      end
      start <= n_start;
      cfg_valid <= n_cfg;
    end
  end

  task automatic add_cfg(logic idx, logic [15:0] v);
    beat_t b;
    b = '{default: '0};
    b.is_cfg = 1; b.cidx = idx; b.cdata = v;
    pending = {pending, b};
  endtask

  task automatic add_box(int x, int y, int w, int h, int s, bit last);
    beat_t b;
    b = '{default: '0};
    b.x = 16'(x); b.y = 16'(y); b.w = 16'(w); b.h = 16'(h); b.s = 16'(s); b.last = last;
    pending = {pending, b};
  endtask

  // A job of n boxes; most are clustered so that overlaps actually occur.
  task automatic add_job(int n);
    int i, bx, by, mode;
    bx = $urandom_range(16'hffff) - 32768;
    by = $urandom_range(16'hffff) - 32768;
    for (i = 0; i < n; i++) begin
      mode = $urandom_range(9);
      if (mode < 7)
        add_box(bx + $urandom_range(2048) - 1024, by + $urandom_range(2048) - 1024,
                $urandom_range(8192, 1024), $urandom_range(8192, 1024),
                ($urandom_range(3) == 0) ? 16'h9000 : $urandom_range(16'hffff), i == n - 1);
      else if (mode < 9)
        add_box($urandom, $urandom, $urandom, $urandom, $urandom, i == n - 1);
      else
        add_box(bx, by, -$urandom_range(4096), $urandom_range(4096) - 2048,
                $urandom, i == n - 1);
    end
  endtask

  initial begin
    int total, big, k;
    total = 0;
    big = 0;
    // Directed: reset values rewritten, then corner jobs.
    add_cfg(CFG_SCORE_THR, SCORE_THR_RESET);
    add_cfg(CFG_IOU_THR, IOU_THR_RESET);
    add_box(-32768, 32767, 32767, -32768, 16'hffff, 1);
    add_box(32767, -32768, -32768, 32767, 0, 1);           // below threshold: empty marker
    add_box(0, 0, 4096, 4096, 16'h8000, 0);                // equal scores, same box
    add_box(0, 0, 4096, 4096, 16'h8000, 0);
    add_box(0, 0, 4096, 4096, 16'h8000, 1);
    add_box(-8192, 0, 2048, 2048, 16'h7fff, 0);            // disjoint boxes
    add_box(8192, 0, 2048, 2048, 16'hc000, 0);
    add_box(0, 0, -2048, -2048, 16'hf000, 0);              // negative sizes
    add_box(0, 0, 0, 0, 16'he000, 1);                      // zero-area boxes
    add_cfg(CFG_IOU_THR, 16'h0000);
    add_cfg(CFG_SCORE_THR, 16'h0000);
    add_box(-8192, 0, 2048, 2048, 0, 0);
    add_box(8192, 0, 2048, 2048, 0, 1);
    add_cfg(CFG_IOU_THR, 16'hffff);
    add_cfg(CFG_SCORE_THR, 16'hffff);
    add_box(0, 0, 4096, 4096, 16'hffff, 0);
    add_box(0, 0, 4096, 4096, 16'hfffe, 0);
    add_box(0, 0, 4096, 4096, 16'hffff, 1);
    total = 13;
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (total < 420) begin
      if ($urandom_range(3) == 0) begin
        k = $urandom_range(5);
        case (k)
          0: add_cfg(CFG_SCORE_THR, 16'h0000);
          1: add_cfg(CFG_SCORE_THR, $urandom_range(16'hffff));
          2: add_cfg(CFG_IOU_THR, 16'h0000);
          3: add_cfg(CFG_IOU_THR, 16'hffff);
          default: add_cfg(k[0] ? CFG_IOU_THR : CFG_SCORE_THR, $urandom_range(16'h4000));
        endcase
      end
      if (big < 3 && $urandom_range(15) == 0) begin
        k = $urandom_range(CAP + 4, CAP - 1);
        big++;
      end else k = $urandom_range(10, 1);
      add_job(k);
      total += k;
    end
    while (pending.size() != 0 || start || cfg_valid) @(posedge clk);
    while (kept_fifo.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Loaded %0d boxes in %0d jobs; %0d result beats checked, %0d mismatches.",
             boxes_in, jobs_done, beats_out, errors);
    if (errors == 0 && kept_fifo.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d results outstanding.", kept_fifo.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
